// ===== hdl/wpi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_pkg: shared definitions for the waypoint path interpolator
// Sizes, request and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package wpi_pkg;

    localparam int MAX_POINTS = 16;
    localparam int FRAC_BITS  = 12;

    localparam int COORD_W  = 32;
    localparam int FRAME_W  = 16;
    localparam int ADDR_W   = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int POINT_W  = 2 * COORD_W;
    localparam int RATIO_W  = FRAME_W + FRAC_BITS;
    localparam int PROD_W   = COORD_W + RATIO_W + 1;
    localparam int DIV_CNT_W = $clog2(RATIO_W);

    // Request codes.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] CFG_POINT_COUNT = 2'd2;
    localparam logic [1:0] CFG_FRAMES_SEG  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_NXT,
        S_CAP,
        S_DIV,
        S_MUL_X,
        S_ADD_X,
        S_ADD_Y,
        S_RST_CAP
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/wpi_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_ram: generic single write port RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module wpi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/waypoint_path_interpolator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_path_interpolator_unit: closed-loop waypoint path interpolation
// Moves a point along linear segments between stored waypoints, one frame
// per tick, using a serial divider and one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  input    | i_in_valid / o_in_ready    | req_type, triggered, point_index, x, y
//  output   | o_out_valid / i_out_ready  | pos_x, pos_y, segment, moving
//  config   | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// A moving tick runs S_RD_NXT, S_CAP, S_DIV, S_MUL_X, S_ADD_X and S_ADD_Y in
// order; in S_DIV the one-bit-per-cycle restoring divider forms the ratio.
// A reset request runs S_RST_CAP; writes, idle ticks and unused codes set
// the registered result on accept. Reset is synchronous and needs no
// clearing pass. The input is not ready while a transaction is in work or a
// result waits on a stalled output.
// ----------------------------------------------------------------------------
module waypoint_path_interpolator_unit
    import wpi_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [31:0]               i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [1:0]                i_req_type,
    input  wire logic                      i_triggered,
    input  wire logic [3:0]                i_point_index,
    input  wire logic signed [COORD_W-1:0] i_point_x,
    input  wire logic signed [COORD_W-1:0] i_point_y,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [COORD_W-1:0]      o_pos_x,
    output logic signed [COORD_W-1:0]      o_pos_y,
    output logic [3:0]                     o_segment,
    output logic                           o_moving
);

    // Control state.
    t_state               r_state, n_state;
    logic [COORD_W-1:0]   r_origin_x, r_origin_y;
    logic [4:0]           r_point_count;
    logic [FRAME_W-1:0]   r_fps;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic [ADDR_W-1:0]    r_seg, n_seg;
    logic [COORD_W-1:0]   r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic                 r_moving, n_moving;
    logic                 r_out_valid, n_out_valid;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    // Datapath.
    logic [ADDR_W-1:0]    r_nxt, n_nxt;
    logic [COORD_W-1:0]   r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [COORD_W-1:0]   r_base_x, n_base_x, r_base_y, n_base_y;
    logic [COORD_W-1:0]   r_dx, n_dx, r_dy, n_dy;
    logic [FRAME_W-1:0]   r_rem, n_rem;
    logic [RATIO_W-1:0]   r_quo, n_quo;
    logic [PROD_W-1:0]    r_prod, n_prod;

    logic                 w_accept;
    logic [31:0]          w_n, w_seg32, w_cur32, w_nxt32, w_slot32;
    logic                 w_go;
    logic                 w_ram_we;
    logic [ADDR_W-1:0]    w_ram_waddr, w_ram_raddr;
    logic [POINT_W-1:0]   w_ram_rdata;
    logic [COORD_W-1:0]   w_rd_x, w_rd_y;
    logic [FRAME_W:0]     w_trial, w_diff;
    logic                 w_ge;
    logic [COORD_W-1:0]   w_mul_a;
    logic signed [PROD_W-1:0] w_prod;

    wpi_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata ({i_point_y, i_point_x}),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_rd_x = w_ram_rdata[COORD_W-1:0];
    assign w_rd_y = w_ram_rdata[POINT_W-1:COORD_W];

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // Points in use, and the segment endpoints for a tick.
    assign w_n      = (32'(r_point_count) > MAX_POINTS) ? 32'(MAX_POINTS)
                                                        : 32'(r_point_count);
    assign w_seg32  = 32'(r_seg);
    assign w_cur32  = (w_seg32 >= w_n) ? 32'd0 : w_seg32;
    assign w_nxt32  = (w_cur32 + 32'd1 >= w_n) ? 32'd0 : w_cur32 + 32'd1;
    assign w_slot32 = 32'(i_point_index);
    assign w_go     = (i_req_type == REQ_TICK) && i_triggered && (w_n >= 32'd2) &&
                      (r_fps != '0);

    assign w_ram_we    = w_accept && (i_req_type == REQ_WRITE) &&
                         (w_slot32 < MAX_POINTS);
    assign w_ram_waddr = w_slot32[ADDR_W-1:0];

    // Restoring divider step.
    assign w_trial = {r_rem, r_quo[RATIO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_fps};
    assign w_diff  = w_trial - {1'b0, r_fps};

    // The one multiplier, shared between the x and y deltas.
    assign w_mul_a = (r_state == S_MUL_X) ? r_dx : r_dy;
    assign w_prod  = $signed(w_mul_a) * $signed({1'b0, r_quo});

    always_comb begin
        n_state     = r_state;
        n_frame     = r_frame;
        n_seg       = r_seg;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_moving    = r_moving;
        n_out_valid = r_out_valid && !i_out_ready;
        n_cnt       = r_cnt;
        n_nxt       = r_nxt;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_base_x    = r_base_x;
        n_base_y    = r_base_y;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_prod      = r_prod;
        w_ram_raddr = r_nxt;

        unique case (r_state)
            S_IDLE: begin
                w_ram_raddr = (i_req_type == REQ_RESET) ? '0 : w_cur32[ADDR_W-1:0];
                if (w_accept) begin
                    if (i_req_type == REQ_RESET) begin
                        n_state  = S_RST_CAP;
                        n_moving = 1'b0;
                    end else if (w_go) begin
                        n_state = S_RD_NXT;
                        n_seg   = w_cur32[ADDR_W-1:0];
                        n_nxt   = w_nxt32[ADDR_W-1:0];
                        n_frame = r_frame + 1'b1;
                    end else begin
                        // Writes, idle ticks, unused codes report with moving clear.
                        n_out_valid = 1'b1;
                        n_moving    = 1'b0;
                    end
                end
            end
            S_RD_NXT: begin
                n_cur_x  = w_rd_x;
                n_cur_y  = w_rd_y;
                n_base_x = r_origin_x + w_rd_x;
                n_base_y = r_origin_y + w_rd_y;
                n_state  = S_CAP;
            end
            S_CAP: begin
                n_dx    = w_rd_x - r_cur_x;
                n_dy    = w_rd_y - r_cur_y;
                n_rem   = '0;
                n_quo   = {r_frame, {FRAC_BITS{1'b0}}};
                n_cnt   = DIV_CNT_W'(RATIO_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_ge ? w_diff[FRAME_W-1:0] : w_trial[FRAME_W-1:0];
                n_quo = {r_quo[RATIO_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_state = S_MUL_X;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MUL_X: begin
                n_prod  = w_prod;
                n_state = S_ADD_X;
            end
            S_ADD_X: begin
                // The arithmetic shift of the product is the floor of the scaled delta.
                n_pos_x = r_base_x + r_prod[FRAC_BITS+COORD_W-1:FRAC_BITS];
                n_prod  = w_prod;
                n_state = S_ADD_Y;
            end
            S_ADD_Y: begin
                n_pos_y     = r_base_y + r_prod[FRAC_BITS+COORD_W-1:FRAC_BITS];
                n_moving    = 1'b1;
                n_out_valid = 1'b1;
                if (r_frame >= r_fps) begin
                    n_frame = '0;
                    n_seg   = r_nxt;
                end
                n_state = S_IDLE;
            end
            S_RST_CAP: begin
                n_frame     = '0;
                n_seg       = '0;
                n_pos_x     = (w_n == 32'd0) ? r_origin_x : r_origin_x + w_rd_x;
                n_pos_y     = (w_n == 32'd0) ? r_origin_y : r_origin_y + w_rd_y;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
        end else begin
            r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_point_count <= '0;
            r_fps         <= '0;
            r_frame       <= '0;
            r_seg         <= '0;
            r_pos_x       <= '0;
            r_pos_y       <= '0;
            r_moving      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_frame     <= n_frame;
            r_seg       <= n_seg;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_moving    <= n_moving;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ORIGIN_X:    r_origin_x    <= i_cfg_data;
                    CFG_ORIGIN_Y:    r_origin_y    <= i_cfg_data;
                    CFG_POINT_COUNT: r_point_count <= i_cfg_data[4:0];
                    CFG_FRAMES_SEG:  r_fps         <= i_cfg_data[FRAME_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nxt    <= n_nxt;
        r_cur_x  <= n_cur_x;
        r_cur_y  <= n_cur_y;
        r_base_x <= n_base_x;
        r_base_y <= n_base_y;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_prod   <= n_prod;
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_segment   = w_seg32[3:0];
    assign o_moving    = r_moving;

endmodule
`default_nettype wire
